// File: rtl/gaussian_blur_3x3_stream_assert.svh
// assertion macros shared by the blur block files
// expects signals named clk and rst_n in the including module
`ifndef GAUSSIAN_BLUR_3X3_STREAM_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock while out of reset
`define GB3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gb3 assertion failed");
// condition this cycle implies property on the next cycle
`define GB3_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("gb3 assertion failed");
`else
`define GB3_ASSERT(lbl, prop)
`define GB3_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// File: rtl/gb3_pkg.sv
// shared constants and types of the 3x3 gaussian blur stream block
// no dependencies
package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 11;
  localparam int PIX_W      = 8;
  // result queue depth, must be a power of two
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(366);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [COL_W-1:0] column;
    logic             last;
  } result_t;

  // up to two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

// File: rtl/gb3_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/gb3_out_fifo.sv
// small result queue, takes up to two items per cycle and gives one while out_stall is low
// depends on gb3_pkg and gaussian_blur_3x3_stream_assert.svh
`include "gaussian_blur_3x3_stream_assert.svh"

module gb3_out_fifo
  import gb3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic             out_stall,
  output logic             out_valid,
  output result_t          out_res,
  output logic [CNT_W-1:0] level
);

  result_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign pop = (count_r != '0) && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[FIFO_AW'(wr_ptr_r + 1'b1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign level     = count_r;

  `GB3_ASSERT(a_fifo_room, ((CNT_W+1)'(count_r) + (CNT_W+1)'(push.count)) <= FIFO_DEPTH)
  `GB3_ASSERT(a_fifo_ptr_match, FIFO_AW'(wr_ptr_r - rd_ptr_r) == count_r[FIFO_AW-1:0])

endmodule

// File: rtl/gaussian_blur_3x3_stream.sv
// top level of the streaming 3x3 gaussian blur
// depends on gb3_pkg, gb3_ram, gb3_out_fifo and gaussian_blur_3x3_stream_assert.svh
//
// Raster pixels of one grey image go in, one item per clock while in_stall
// is low, and blurred pixels come out one row behind. The block can take one
// input item every cycle: each item needs one read and one write of each line
// store ram, and the two ram ports carry exactly that in one cycle. An item's
// results enter an eight-entry result queue at the clock edge after it is
// accepted (the ram read is registered at the accepting edge, the window
// update and the sums fill the next cycle), so out_valid can rise at that
// edge; the queue gives one result per cycle while out_stall is low. The last
// column of a row gives two results and column 0 none, so the queue evens this
// out and in_stall stays low at full rate unless the far side holds
// out_stall. The first row of a frame gives no results; a row that ends on a
// flush item rearms the block for a new frame. The width register may only be
// written while the block is idle; cfg_ready is always high. There is no
// clearing pass after reset: line store contents are only used after being
// written in the same frame geometry.
`include "gaussian_blur_3x3_stream_assert.svh"

module gaussian_blur_3x3_stream
  import gb3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input item channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [PIX_W-1:0] in_pixel,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_blurred,
  output logic [COL_W-1:0] out_column,
  output logic             out_last_of_run,
  // width register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // window layout: row-major, row 0 on top, column 0 on the left
  typedef logic [8:0][PIX_W-1:0] win_t;

  function automatic win_t shift_col(win_t w, logic [PIX_W-1:0] top,
                                     logic [PIX_W-1:0] mid,
                                     logic [PIX_W-1:0] bot);
    win_t             s;
    logic [PIX_W-1:0] col [3];
    col[0] = top;
    col[1] = mid;
    col[2] = bot;
    s = w;
    for (int r = 0; r < 3; r++) begin
      s[r*3]     = w[r*3+1];
      s[r*3 + 1] = w[r*3+2];
      s[r*3 + 2] = col[r];
    end
    return s;
  endfunction

  // each term truncated on its own, the sum stays below 256
  function automatic logic [PIX_W-1:0] blur(win_t w);
    logic [PIX_W-1:0] corners, edges;
    corners = {4'd0, w[0][7:4]} + {4'd0, w[2][7:4]}
            + {4'd0, w[6][7:4]} + {4'd0, w[8][7:4]};
    edges   = {3'd0, w[1][7:3]} + {3'd0, w[3][7:3]}
            + {3'd0, w[5][7:3]} + {3'd0, w[7][7:3]};
    return corners + edges + {2'd0, w[4][7:2]};
  endfunction

  // width register and effective width
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] width_eff, width_last;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (width_r < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (width_r > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = width_r;
    end
    width_last = width_eff - 1'b1;
  end

  // input side: column counter and frame phase
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic             first_row_r, first_row_nxt;
  logic             in_acc, last0;
  logic [PIX_W-1:0] pix0;
  logic [CNT_W:0]   queue_need;
  logic [CNT_W-1:0] level;

  // stage register, holds the accepted item while ram data comes back
  logic             s1_valid_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;

  // keep room for the item in the stage plus the one coming in
  assign queue_need = (CNT_W+1)'(level) + (s1_valid_r ? (CNT_W+1)'(2) : '0);
  assign in_stall   = queue_need > (CNT_W+1)'(FIFO_DEPTH - 2);
  assign in_acc     = in_valid && !in_stall;

  assign pix0  = (in_command == CMD_FLUSH) ? '0 : in_pixel;
  assign last0 = {{(CFG_W-COL_W){1'b0}}, col_cnt_r} >= width_last;

  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    first_row_nxt = first_row_r;
    if (in_acc) begin
      if (last0) begin
        col_cnt_nxt = '0;
        if (first_row_r) begin
          // a flush that ends the first row leaves the block in that phase
          first_row_nxt = (in_command == CMD_FLUSH);
        end else if (in_command == CMD_FLUSH) begin
          first_row_nxt = 1'b1;
        end
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      col_cnt_r   <= '0;
      first_row_r <= 1'b1;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_data;
      end
      col_cnt_r   <= col_cnt_nxt;
      first_row_r <= first_row_nxt;
      s1_valid_r  <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_first_r <= first_row_r;
      s1_last_r  <= last0;
      s1_col_r   <= col_cnt_r;
      s1_pix_r   <= pix0;
    end
  end

  // line stores: read at the incoming column, written back from the stage register in the next cycle
  logic [PIX_W-1:0] up_rdata, mid_rdata, up_wdata;
  logic             line_we;

  assign line_we  = s1_valid_r;
  assign up_wdata = s1_first_r ? '0 : mid_rdata;

  gb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_col_r),
    .wdata (up_wdata),
    .raddr (col_cnt_r),
    .rdata (up_rdata)
  );

  gb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .raddr (col_cnt_r),
    .rdata (mid_rdata)
  );

  // window update and result generation
  win_t  win_r, win_nxt;
  win_t  win_one, win_two;
  push_t push;
  logic  s1_work;

  assign s1_work = s1_valid_r && !s1_first_r;

  always_comb begin
    // column 0 starts from an empty window (zero padding on the left)
    win_one = shift_col((s1_col_r == '0) ? '0 : win_r, up_rdata, mid_rdata, s1_pix_r);
    // after the last column, the right neighbor is padding
    win_two = shift_col(win_one, '0, '0, '0);
    win_nxt = win_r;
    push    = '0;
    if (s1_work) begin
      win_nxt = s1_last_r ? win_two : win_one;
      push.count = 2'(s1_col_r != '0) + 2'(s1_last_r);
      if (s1_col_r != '0) begin
        push.res0.blurred = blur(win_one);
        push.res0.column  = s1_col_r - 1'b1;
        push.res0.last    = !s1_last_r;
      end else begin
        push.res0.blurred = blur(win_two);
        push.res0.column  = s1_col_r;
        push.res0.last    = 1'b1;
      end
      push.res1.blurred = blur(win_two);
      push.res1.column  = s1_col_r;
      push.res1.last    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  // result queue
  result_t out_res;

  gb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .level     (level)
  );

  assign out_blurred     = out_res.blurred;
  assign out_column      = out_res.column;
  assign out_last_of_run = out_res.last;

  `GB3_ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_valid_r)
  `GB3_ASSERT_NEXT(a_row_end_wraps, in_acc && last0, col_cnt_r == '0)
  `GB3_ASSERT(a_first_row_silent, !(s1_valid_r && s1_first_r) || (push.count == 2'd0))
  `GB3_ASSERT(a_double_at_row_end, (push.count != 2'd2) || (s1_last_r && push.res1.last && !push.res0.last))

endmodule
